// ===== src/bpm_pkg.sv =====
`timescale 1ns / 1ps

package bpm_pkg;

    localparam int SLOTS     = 32;
    localparam int ADDR_BITS = 32;

    // Field widths fixed by the request and result formats
    localparam int OP_W       = 2;
    localparam int ADDR_IN_W  = 32;
    localparam int SLOT_IN_W  = 5;
    localparam int STATUS_W   = 2;
    localparam int ASSIGN_W   = 5;
    localparam int MASK_W     = 32;
    localparam int COUNT_OUT_W = 6;

    // Derived widths
    localparam int ADDR_W     = (ADDR_BITS < ADDR_IN_W) ? ADDR_BITS : ADDR_IN_W;
    localparam int SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PTR_W      = $clog2(SLOTS + 1);
    localparam int CNT_W      = $clog2(SLOTS + 1);
    localparam int SLOT_CMP_W = 7;

    localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    // Token that walks down the slot cells, one cell per cycle while the row is not stalled
    typedef struct packed {
        logic                   is_check;
        logic                   wr_en;
        logic                   clr_en;
        logic [SLOT_IDX_W-1:0]  target;
        logic [ADDR_W-1:0]      addr;
        logic [STATUS_W-1:0]    status;
        logic [ASSIGN_W-1:0]    assigned_slot;
        logic [COUNT_OUT_W-1:0] active_count;
        logic                   hit;
        logic [MASK_W-1:0]      hit_mask;
    } tok_t;

endpackage

// ===== src/bpm_req_if.sv =====
`timescale 1ns / 1ps

interface bpm_req_if;
    logic                           valid;
    logic                           ready;
    logic [bpm_pkg::OP_W-1:0]       op;
    logic [bpm_pkg::ADDR_IN_W-1:0]  address;
    logic [bpm_pkg::SLOT_IN_W-1:0]  slot_number;

    modport source (output valid, output op, output address, output slot_number,
                    input ready);
    modport sink   (input valid, input op, input address, input slot_number,
                    output ready);
endinterface

// ===== src/bpm_rsp_if.sv =====
`timescale 1ns / 1ps

interface bpm_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [bpm_pkg::STATUS_W-1:0]     status;
    logic [bpm_pkg::ASSIGN_W-1:0]     assigned_slot;
    logic                             hit;
    logic [bpm_pkg::MASK_W-1:0]       hit_mask;
    logic [bpm_pkg::COUNT_OUT_W-1:0]  active_count;

    modport source (output valid, output status, output assigned_slot, output hit,
                    output hit_mask, output active_count, input ready);
    modport sink   (input valid, input status, input assigned_slot, input hit,
                    input hit_mask, input active_count, output ready);
endinterface

// ===== src/bpm_head.sv =====
`timescale 1ns / 1ps

module bpm_head (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic                           in_valid,
    input  logic [bpm_pkg::OP_W-1:0]       op,
    input  logic [bpm_pkg::ADDR_IN_W-1:0]  address,
    input  logic [bpm_pkg::SLOT_IN_W-1:0]  slot_number,
    output logic                           out_valid,
    output bpm_pkg::tok_t                  out_tok
);

    logic [bpm_pkg::PTR_W-1:0]      free_link_reg [bpm_pkg::SLOTS];
    logic [bpm_pkg::PTR_W-1:0]      free_top_reg;
    logic [bpm_pkg::PTR_W-1:0]      free_top_next;
    logic [bpm_pkg::CNT_W-1:0]      live_count_reg;
    logic [bpm_pkg::CNT_W-1:0]      live_count_next;
    logic [bpm_pkg::SLOTS-1:0]      active_reg;
    logic [bpm_pkg::SLOTS-1:0]      active_next;
    logic                           valid_reg;
    bpm_pkg::tok_t                  tok_reg;
    bpm_pkg::tok_t                  tok_next;

    logic                           accept;
    logic [bpm_pkg::SLOT_IDX_W-1:0] top_idx;
    logic [bpm_pkg::SLOT_CMP_W-1:0] slot_ext;
    logic [bpm_pkg::SLOT_IDX_W-1:0] del_idx;
    logic                           create_ok;
    logic                           delete_ok;

    assign accept   = in_valid && advance;
    assign top_idx  = free_top_reg[bpm_pkg::SLOT_IDX_W-1:0];
    assign slot_ext = bpm_pkg::SLOT_CMP_W'(slot_number);
    assign del_idx  = slot_ext[bpm_pkg::SLOT_IDX_W-1:0];

    // A damaged list head (end mark or an active slot) reads as a full table
    assign create_ok = (op == bpm_pkg::OP_CREATE)
                    && (live_count_reg < bpm_pkg::CNT_W'(bpm_pkg::SLOTS))
                    && (free_top_reg < bpm_pkg::PTR_W'(bpm_pkg::SLOTS))
                    && !active_reg[top_idx];
    assign delete_ok = (op == bpm_pkg::OP_DELETE)
                    && (slot_ext < bpm_pkg::SLOT_CMP_W'(bpm_pkg::SLOTS))
                    && active_reg[del_idx];

    always_comb
    begin
        free_top_next   = free_top_reg;
        live_count_next = live_count_reg;
        active_next     = active_reg;
        if (create_ok)
        begin
            free_top_next        = free_link_reg[top_idx];
            live_count_next      = live_count_reg + 1'b1;
            active_next[top_idx] = 1'b1;
        end
        else if (delete_ok)
        begin
            free_top_next        = bpm_pkg::PTR_W'(del_idx);
            active_next[del_idx] = 1'b0;
            if (live_count_reg != '0)
            begin
                live_count_next = live_count_reg - 1'b1;
            end
        end
    end

    always_comb
    begin
        tok_next               = '0;
        tok_next.is_check      = (op == bpm_pkg::OP_CHECK);
        tok_next.wr_en         = create_ok;
        tok_next.clr_en        = delete_ok;
        tok_next.target        = create_ok ? top_idx : del_idx;
        tok_next.addr          = address[bpm_pkg::ADDR_W-1:0];
        tok_next.assigned_slot = create_ok ? bpm_pkg::ASSIGN_W'(top_idx) : '0;
        tok_next.active_count  = bpm_pkg::COUNT_OUT_W'(live_count_next);
        unique case (op)
            bpm_pkg::OP_CREATE: tok_next.status = create_ok ? bpm_pkg::ST_OK
                                                            : bpm_pkg::ST_FULL;
            bpm_pkg::OP_DELETE: tok_next.status = delete_ok ? bpm_pkg::ST_OK
                                                            : bpm_pkg::ST_NOT_FOUND;
            default:            tok_next.status = bpm_pkg::ST_OK;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bpm_pkg::SLOTS; i++)
            begin
                free_link_reg[i] <= bpm_pkg::PTR_W'(i + 1);
            end
            free_top_reg   <= '0;
            live_count_reg <= '0;
            active_reg     <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                valid_reg <= in_valid;
            end
            if (accept)
            begin
                if (delete_ok)
                begin
                    free_link_reg[del_idx] <= free_top_reg;
                end
                free_top_reg   <= free_top_next;
                live_count_reg <= live_count_next;
                active_reg     <= active_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

endmodule

// ===== src/bpm_cell.sv =====
`timescale 1ns / 1ps

module bpm_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic [bpm_pkg::SLOT_IDX_W-1:0] cell_id,
    input  logic                           in_valid,
    input  bpm_pkg::tok_t                  in_tok,
    output logic                           out_valid,
    output bpm_pkg::tok_t                  out_tok
);

    logic [bpm_pkg::ADDR_W-1:0] addr_reg;
    logic [bpm_pkg::ADDR_W-1:0] addr_next;
    logic                       active_reg;
    logic                       active_next;
    logic                       valid_reg;
    bpm_pkg::tok_t              tok_reg;
    bpm_pkg::tok_t              tok_next;

    logic                       step;
    logic                       mine;
    logic                       match;

    assign step  = advance && in_valid;
    assign mine  = (in_tok.target == cell_id);
    assign match = in_tok.is_check && active_reg && (addr_reg == in_tok.addr);

    always_comb
    begin
        addr_next   = addr_reg;
        active_next = active_reg;
        if (step && mine && in_tok.wr_en)
        begin
            addr_next   = in_tok.addr;
            active_next = 1'b1;
        end
        else if (step && mine && in_tok.clr_en)
        begin
            active_next = 1'b0;
        end
    end

    // Slots past the mask width still raise hit; the shift drops their bit
    always_comb
    begin
        tok_next = in_tok;
        if (match)
        begin
            tok_next.hit      = 1'b1;
            tok_next.hit_mask = in_tok.hit_mask
                              | (bpm_pkg::MASK_W'(1) << cell_id);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            if (advance)
            begin
                valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg <= addr_next;
        if (advance)
        begin
            tok_reg <= tok_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;

endmodule

// ===== src/breakpoint_match_table.sv =====
`timescale 1ns / 1ps

// Channel  Modport  Direction  Moves
// req      sink     in         op, address, slot_number
// rsp      source   out        status, assigned_slot, hit, hit_mask, active_count
//
// Every request is decided at the head (free list, count, status) and then walks a
// row of SLOTS cells, one cell per cycle while the row is not stalled; its response
// leaves the last cell. One request enters per cycle unless the row is stalled.
// Reset clears all slots to inactive and rebuilds the free list 0..SLOTS-1 at once.
// A response held by rsp.ready low stalls the whole row and drops req.ready.

module breakpoint_match_table (
    input  logic     clk,
    input  logic     rst_n,
    bpm_req_if.sink  req,
    bpm_rsp_if.source rsp
);

    logic                 advance;
    logic                 chain_valid [bpm_pkg::SLOTS + 1];
    bpm_pkg::tok_t        chain_tok   [bpm_pkg::SLOTS + 1];

    assign advance   = !chain_valid[bpm_pkg::SLOTS] || rsp.ready;
    assign req.ready = advance;

    bpm_head u_head (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .in_valid    (req.valid),
        .op          (req.op),
        .address     (req.address),
        .slot_number (req.slot_number),
        .out_valid   (chain_valid[0]),
        .out_tok     (chain_tok[0])
    );

    for (genvar k = 0; k < bpm_pkg::SLOTS; k++)
    begin : g_cell
        bpm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .cell_id   (bpm_pkg::SLOT_IDX_W'(k)),
            .in_valid  (chain_valid[k]),
            .in_tok    (chain_tok[k]),
            .out_valid (chain_valid[k + 1]),
            .out_tok   (chain_tok[k + 1])
        );
    end

    assign rsp.valid         = chain_valid[bpm_pkg::SLOTS];
    assign rsp.status        = chain_tok[bpm_pkg::SLOTS].status;
    assign rsp.assigned_slot = chain_tok[bpm_pkg::SLOTS].assigned_slot;
    assign rsp.hit           = chain_tok[bpm_pkg::SLOTS].hit;
    assign rsp.hit_mask      = chain_tok[bpm_pkg::SLOTS].hit_mask;
    assign rsp.active_count  = chain_tok[bpm_pkg::SLOTS].active_count;

endmodule

// ===== src/bpm_checker.sv =====
`timescale 1ns / 1ps

module bpm_assertions (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_ready,
    input  logic                             rsp_valid,
    input  logic                             rsp_ready,
    input  logic [bpm_pkg::STATUS_W-1:0]     rsp_status,
    input  logic [bpm_pkg::ASSIGN_W-1:0]     rsp_assigned_slot,
    input  logic                             rsp_hit,
    input  logic [bpm_pkg::MASK_W-1:0]       rsp_hit_mask,
    input  logic [bpm_pkg::COUNT_OUT_W-1:0]  rsp_active_count
);

    // Held response keeps its hit mask and active count
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit_mask)
                                    && $stable(rsp_active_count))
        else $error("response changed while stalled");

    // Only a stalled response may block new requests
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("request side blocked without output stall");

    a_mask_hit: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_hit_mask != '0) |-> rsp_hit)
        else $error("mask bit set without hit");

    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != bpm_pkg::ST_OK)
            |-> !rsp_hit && (rsp_hit_mask == '0) && (rsp_assigned_slot == '0))
        else $error("failed request carries hit or slot data");

    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> bpm_pkg::SLOT_CMP_W'(rsp_active_count)
                      <= bpm_pkg::SLOT_CMP_W'(bpm_pkg::SLOTS))
        else $error("active count beyond table size");

endmodule

bind breakpoint_match_table bpm_assertions u_bpm_assertions (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_ready         (req.ready),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_status        (rsp.status),
    .rsp_assigned_slot (rsp.assigned_slot),
    .rsp_hit           (rsp.hit),
    .rsp_hit_mask      (rsp.hit_mask),
    .rsp_active_count  (rsp.active_count)
);
